/* rtl/rpfa_pkg.sv */
// shared types, codes and sizes for the page frame allocator
package rpfa_pkg;

    localparam int unsigned FRAMES_DEF     = 4096;
    localparam int unsigned COUNT_BITS_DEF = 8;
    localparam int unsigned REG_W          = 13;
    localparam int unsigned IDX_W          = 12;
    localparam int unsigned OP_W           = 2;
    localparam int unsigned ST_W           = 3;
    localparam int unsigned CNT_W          = 8;
    localparam logic [REG_W-1:0] FRAME_COUNT_RST = 13'd4096;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_SHARE   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_OOM      = 3'd1;
    localparam logic [ST_W-1:0] ST_OUTSIDE  = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

    localparam logic CFG_FIRST_FRAME = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic             reject;
    } t_cmd;

    typedef struct packed {
        logic [REG_W-1:0] first;
        logic [REG_W-1:0] last;
    } t_win;

endpackage

/* rtl/rpfa_ram.sv */
// generic single write port ram with registered read
module rpfa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/rpfa_front.sv */
// request intake: config registers, window classification and command queue
module rpfa_front #(
    parameter int unsigned FRAMES = rpfa_pkg::FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rpfa_pkg::OP_W-1:0]   i_operation,
    input  logic [rpfa_pkg::IDX_W-1:0]  i_frame_index,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [rpfa_pkg::REG_W-1:0]  i_cfg_wdata,
    input  logic                        i_clearing,
    input  logic                        i_pop,
    output logic                        o_cmd_valid,
    output rpfa_pkg::t_cmd              o_cmd,
    output rpfa_pkg::t_win              o_win
);
    import rpfa_pkg::*;

    localparam logic [REG_W:0] FRAMES_CAP = (FRAMES > 8192) ? (REG_W+1)'(8192)
                                                           : (REG_W+1)'(FRAMES);

    logic [REG_W-1:0] r_first, r_count;
    logic [REG_W-1:0] win_end;
    t_cmd             r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             push;
    t_cmd             cmd_in;
    logic [REG_W-1:0] idx_ext;

    assign win_end = ({1'b0, r_count} < FRAMES_CAP) ? r_count : FRAMES_CAP[REG_W-1:0];
    assign idx_ext = REG_W'(i_frame_index);
    assign busy    = (r_cnt == 2'd2) || i_clearing;
    assign push    = start && !busy;

    always_comb begin
        cmd_in.op     = i_operation;
        cmd_in.idx    = i_frame_index;
        cmd_in.reject = (i_operation != OP_RELEASE && i_operation != OP_SHARE)
                        || idx_ext < r_first || idx_ext >= win_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_count <= FRAME_COUNT_RST;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_FIRST_FRAME) begin
                    r_first <= i_cfg_wdata;
                end else begin
                    r_count <= i_cfg_wdata;
                end
            end
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign o_win.first = r_first;
    assign o_win.last  = win_end;

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> busy) else $error("full queue not busy");
endmodule

/* rtl/rpfa_back.sv */
// request execution: count store, clearing pass, free frame scan and results
module rpfa_back #(
    parameter int unsigned FRAMES     = rpfa_pkg::FRAMES_DEF,
    parameter int unsigned COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  rpfa_pkg::t_cmd              i_cmd,
    input  rpfa_pkg::t_win              i_win,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_valid,
    output logic [rpfa_pkg::ST_W-1:0]   o_status,
    output logic [rpfa_pkg::IDX_W-1:0]  o_result_frame,
    output logic [rpfa_pkg::CNT_W-1:0]  o_ref_count,
    output logic                        o_frame_freed,
    output logic [rpfa_pkg::REG_W-1:0]  o_free_frames
);
    import rpfa_pkg::*;

    localparam int unsigned AW = $clog2(FRAMES);
    localparam int unsigned AC = $clog2(FRAMES + 1);
    localparam int unsigned FW = (AC > REG_W) ? AC : REG_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHK, S_SCAN} t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic [REG_W-1:0]    r_scan;
    t_cmd                r_cmd;
    logic [AC-1:0]       r_alloc, n_alloc;
    logic                r_valid;
    logic [ST_W-1:0]     r_status;
    logic [IDX_W-1:0]    r_frame;
    logic [CNT_W-1:0]    r_refc;
    logic                r_freed;
    logic [REG_W-1:0]    r_free;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [COUNT_BITS-1:0] wdata, rdata;
    logic [REG_W-1:0]    scan_nx;
    logic [REG_W-1:0]    win_size;
    logic [FW-1:0]       free_w;

    rpfa_ram #(.WIDTH(COUNT_BITS), .DEPTH(FRAMES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign scan_nx  = r_scan + 1'b1;
    assign win_size = (i_win.last > i_win.first) ? i_win.last - i_win.first : '0;

    always_comb begin
        we      = 1'b0;
        waddr   = r_clr;
        wdata   = '0;
        raddr   = AW'(scan_nx);
        n_alloc = r_alloc;
        o_pop   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
            end
            S_IDLE: begin
                o_pop = i_cmd_valid;
                raddr = (i_cmd.op == OP_ALLOC) ? AW'(i_win.first) : AW'(i_cmd.idx);
            end
            S_CHK: begin
                waddr = AW'(r_cmd.idx);
                if (rdata != '0) begin
                    if (r_cmd.op == OP_RELEASE) begin
                        we    = 1'b1;
                        wdata = rdata - 1'b1;
                        if (rdata == COUNT_BITS'(1) && r_alloc != '0) begin
                            n_alloc = r_alloc - 1'b1;
                        end
                    end else if (rdata != CMAX) begin
                        we    = 1'b1;
                        wdata = rdata + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                waddr = AW'(r_scan);
                if (rdata == '0) begin
                    we      = 1'b1;
                    wdata   = COUNT_BITS'(1);
                    n_alloc = r_alloc + 1'b1;
                end
            end
            default: ;
        endcase
        free_w = (FW'(win_size) > FW'(n_alloc)) ? FW'(win_size) - FW'(n_alloc) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_alloc <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_alloc <= n_alloc;
            r_free  <= free_w[REG_W-1:0];
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(FRAMES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_frame <= i_cmd.idx;
                        r_refc  <= '0;
                        r_freed <= 1'b0;
                        if (i_cmd.op == OP_ALLOC) begin
                            r_frame <= '0;
                            r_scan  <= i_win.first;
                            if (i_win.first >= i_win.last) begin
                                r_valid  <= 1'b1;
                                r_status <= ST_OOM;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if (i_cmd.reject) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_OUTSIDE;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (rdata == '0) begin
                        r_status <= ST_NOT_ALLOC;
                    end else if (r_cmd.op == OP_RELEASE) begin
                        r_status <= ST_OK;
                        r_refc   <= CNT_W'(wdata);
                        r_freed  <= (rdata == COUNT_BITS'(1));
                    end else if (rdata == CMAX) begin
                        r_status <= ST_OVERFLOW;
                        r_refc   <= CNT_W'(CMAX);
                    end else begin
                        r_status <= ST_OK;
                        r_refc   <= CNT_W'(wdata);
                    end
                end
                S_SCAN: begin
                    r_scan <= scan_nx;
                    if (rdata == '0) begin
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                        r_status <= ST_OK;
                        r_frame  <= IDX_W'(r_scan);
                        r_refc   <= CNT_W'(1);
                    end else if (scan_nx >= i_win.last) begin
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                        r_status <= ST_OOM;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clearing     = (r_state == S_CLEAR);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_result_frame = r_frame;
    assign o_ref_count    = r_refc;
    assign o_frame_freed  = r_freed;
    assign o_free_frames  = r_free;

    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !r_valid) else $error("result during clearing pass");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE) else $error("pop outside idle");
    a_alloc_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cmd.op == OP_ALLOC && r_status == ST_OK) |-> r_refc == CNT_W'(1))
        else $error("allocation count not one");
    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_freed) |-> (r_status == ST_OK && r_refc == '0))
        else $error("freed flag with wrong status");
endmodule

/* rtl/refcounted_page_frame_allocator_unit.sv */
// top level of the reference counted page frame allocator
//
// usage: a request (i_operation, i_frame_index) is taken on a clock edge with start
// high and busy low. requests go into a two entry queue; the execution side takes
// them one at a time and puts each result on the o_ ports for one cycle with
// o_valid high. the receiver cannot stall, so results are never held back.
// path: an accepted request is registered in the queue, waits behind any earlier
// ones and is taken by the idle state, which answers a rejected request itself; a
// release or share goes on to a check state that reads the count store. allocate
// scans it from first_frame upward, one frame per cycle limited by the single ram
// read port, examining at most the window size; an empty window gets OOM unscanned.
// throughput: one request in flight in execution; the queue lets up to two more
// wait, and busy rises when it is full.
// reset: i_rst_n (synchronous, active low) restores the config registers and then
// runs a clearing pass that zeroes every count store entry, during which busy is
// high. config writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) take effect at once and
// should only be made while no request is pending.
module refcounted_page_frame_allocator_unit #(
    parameter int unsigned FRAMES     = rpfa_pkg::FRAMES_DEF,
    parameter int unsigned COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rpfa_pkg::OP_W-1:0]   i_operation,
    input  logic [rpfa_pkg::IDX_W-1:0]  i_frame_index,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [rpfa_pkg::REG_W-1:0]  i_cfg_wdata,
    output logic                        o_valid,
    output logic [rpfa_pkg::ST_W-1:0]   o_status,
    output logic [rpfa_pkg::IDX_W-1:0]  o_result_frame,
    output logic [rpfa_pkg::CNT_W-1:0]  o_ref_count,
    output logic                        o_frame_freed,
    output logic [rpfa_pkg::REG_W-1:0]  o_free_frames
);
    import rpfa_pkg::*;

    logic  clearing, pop, cmd_valid;
    t_cmd  cmd;
    t_win  win;

    rpfa_front #(.FRAMES(FRAMES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_frame_index(i_frame_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_clearing   (clearing),
        .i_pop        (pop),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .o_win        (win)
    );

    rpfa_back #(.FRAMES(FRAMES), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .i_win         (win),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_result_frame(o_result_frame),
        .o_ref_count   (o_ref_count),
        .o_frame_freed (o_frame_freed),
        .o_free_frames (o_free_frames)
    );
endmodule
